FILE: design/bmce_pkg.sv
// types, codes and constants shared by the bootloader memory command engine
`default_nettype none

package bmce_pkg;

  // protocol bytes
  localparam logic [7:0] AckByte      = 8'h79;
  localparam logic [7:0] WriteCmd     = 8'h31;
  localparam logic [7:0] WriteCmdInv  = 8'hCE;
  localparam logic [7:0] ReadCmd      = 8'h11;
  localparam logic [7:0] ReadCmdInv   = 8'hEE;

  // block length limits
  localparam int unsigned MaxBlockBytes = 256;
  localparam int unsigned LenW          = 9;

  // job queue depth between front and back
  localparam int unsigned QueueDepth = 2;

  // number of bytes a single job can carry
  localparam int unsigned JobBytes = 5;
  localparam int unsigned JobCntW  = 3;

  typedef enum logic [1:0] {
    OP_WR_START = 2'd0,
    OP_RD_START = 2'd1,
    OP_DATA     = 2'd2,
    OP_RX       = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    K_TX  = 2'd0,
    K_RD  = 2'd1,
    K_FIN = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NACK  = 2'd1,
    ST_PLACE = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_ACK_CMD,
    PH_ACK_ADDR,
    PH_WR_DATA,
    PH_WR_ACK,
    PH_RD_ACK,
    PH_RD_DATA
  } phase_e;

  // one job: a run of bytes, optionally followed by a finish beat
  typedef struct packed {
    kind_e                byte_kind;
    logic [8*JobBytes-1:0] bytes;   // first byte in the lowest bits
    logic [JobCntW-1:0]   nbytes;
    logic                 fin;
    status_e              status;
  } job_t;

endpackage

`default_nettype wire

FILE: design/bmce_front.sv
// front part: accepts input beats, tracks the command phase and issues jobs
`default_nettype none

module bmce_front
  import bmce_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_BYTES = MaxBlockBytes
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire logic [1:0]     opcode_i,
  input  wire logic [31:0]    address_i,
  input  wire logic [LenW-1:0] block_length_i,
  input  wire logic [7:0]     byte_in_i,
  output logic                job_valid_o,
  output job_t                job_o,
  input  wire logic           job_ready_i
);

  localparam logic [LenW-1:0] MaxLen = LenW'(MAX_BLOCK_BYTES);

  phase_e          phase_q, phase_d;
  logic            is_read_q, is_read_d;
  logic [31:0]     addr_q, addr_d;
  logic [LenW-1:0] len_q, len_d;
  logic [LenW-1:0] done_q, done_d;
  logic [7:0]      xor_q, xor_d;

  logic            accept;
  logic            has_job;
  job_t            job;
  logic [LenW-1:0] blen;
  logic [LenW-1:0] done_inc;
  logic [7:0]      xor_new;
  logic [7:0]      len1;
  logic [7:0]      addr_x;

  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i & job_ready_i;
  assign job_valid_o = accept & has_job;
  assign job_o       = job;

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      is_read_q <= 1'b0;
      addr_q    <= '0;
      len_q     <= '0;
      done_q    <= '0;
      xor_q     <= '0;
    end else if (accept) begin
      phase_q   <= phase_d;
      is_read_q <= is_read_d;
      addr_q    <= addr_d;
      len_q     <= len_d;
      done_q    <= done_d;
      xor_q     <= xor_d;
    end
  end

  // helper values
  always_comb begin
    if (block_length_i == '0) begin
      blen = LenW'(1);
    end else if (block_length_i > MaxLen) begin
      blen = MaxLen;
    end else begin
      blen = block_length_i;
    end
    done_inc = done_q + LenW'(1);
    xor_new  = xor_q ^ byte_in_i;
    len1     = 8'(len_q - LenW'(1));
    addr_x   = addr_q[31:24] ^ addr_q[23:16] ^ addr_q[15:8] ^ addr_q[7:0];
  end

  // phase sequencing and job selection
  always_comb begin
    phase_d   = phase_q;
    is_read_d = is_read_q;
    addr_d    = addr_q;
    len_d     = len_q;
    done_d    = done_q;
    xor_d     = xor_q;
    has_job   = 1'b1;
    job       = '{byte_kind: K_TX, bytes: '0, nbytes: '0, fin: 1'b0, status: ST_OK};

    unique case (phase_q)
      PH_IDLE: begin
        if (opcode_i == OP_WR_START || opcode_i == OP_RD_START) begin
          is_read_d  = (opcode_i == OP_RD_START);
          addr_d     = address_i;
          len_d      = blen;
          done_d     = '0;
          xor_d      = '0;
          phase_d    = PH_ACK_CMD;
          job.nbytes = JobCntW'(2);
          job.bytes  = (opcode_i == OP_RD_START) ? {24'h0, ReadCmdInv, ReadCmd}
                                                 : {24'h0, WriteCmdInv, WriteCmd};
        end else begin
          job.fin    = 1'b1;
          job.status = ST_PLACE;
        end
      end

      PH_WR_DATA: begin
        if (opcode_i == OP_DATA) begin
          xor_d      = xor_new;
          done_d     = done_inc;
          job.bytes  = {24'h0, xor_new, byte_in_i};
          if (done_inc >= len_q) begin
            job.nbytes = JobCntW'(2);
            phase_d    = PH_WR_ACK;
          end else begin
            job.nbytes = JobCntW'(1);
          end
        end else begin
          job.fin    = 1'b1;
          job.status = ST_PLACE;
          phase_d    = PH_IDLE;
        end
      end

      default: begin
        if (opcode_i != OP_RX) begin
          job.fin    = 1'b1;
          job.status = ST_PLACE;
          phase_d    = PH_IDLE;
        end else if (phase_q == PH_RD_DATA) begin
          // pass the received byte through, finish after the last one
          done_d        = done_inc;
          job.byte_kind = K_RD;
          job.bytes     = {32'h0, byte_in_i};
          job.nbytes    = JobCntW'(1);
          if (done_inc >= len_q) begin
            job.fin = 1'b1;
            phase_d = PH_IDLE;
          end
        end else if (byte_in_i != AckByte) begin
          job.fin    = 1'b1;
          job.status = ST_NACK;
          phase_d    = PH_IDLE;
        end else begin
          unique case (phase_q)
            PH_ACK_CMD: begin
              // address most significant byte first, then its checksum
              job.bytes  = {addr_x, addr_q[7:0], addr_q[15:8], addr_q[23:16],
                            addr_q[31:24]};
              job.nbytes = JobCntW'(5);
              phase_d    = PH_ACK_ADDR;
            end
            PH_ACK_ADDR: begin
              done_d = '0;
              job.bytes = {24'h0, ~len1, len1};
              if (is_read_q) begin
                job.nbytes = JobCntW'(2);
                phase_d    = PH_RD_ACK;
              end else begin
                job.nbytes = JobCntW'(1);
                xor_d      = len1;
                phase_d    = PH_WR_DATA;
              end
            end
            PH_WR_ACK: begin
              job.fin = 1'b1;
              phase_d = PH_IDLE;
            end
            PH_RD_ACK: begin
              has_job = 1'b0;
              done_d  = '0;
              phase_d = PH_RD_DATA;
            end
            default: begin
              job.fin    = 1'b1;
              job.status = ST_PLACE;
              phase_d    = PH_IDLE;
            end
          endcase
        end
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: design/bmce_queue.sv
// short job queue between the front and back parts
`default_nettype none

module bmce_queue
  import bmce_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_valid_i,
  output logic      push_ready_o,
  input  wire job_t push_job_i,
  output logic      pop_valid_o,
  input  wire logic pop_ready_i,
  output job_t      pop_job_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  job_t            mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            push, pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign pop_valid_o  = (cnt_q != '0);
  assign push         = push_valid_i & push_ready_o;
  assign pop          = pop_valid_o & pop_ready_i;
  assign pop_job_o    = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_job_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (push && !pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (pop && !push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/bmce_back.sv
// back part: expands each job into result beats, one beat per cycle while not stalled
`default_nettype none

module bmce_back
  import bmce_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic job_valid_i,
  output logic      job_ready_o,
  input  wire job_t job_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output logic [1:0] kind_o,
  output logic [7:0] byte_out_o,
  output logic [1:0] status_o,
  output logic      last_o
);

  logic cur_valid_q;
  job_t cur_q;
  logic fire, load;

  // current beat taken from the head of the job being sent
  always_comb begin
    if (cur_q.nbytes != '0) begin
      kind_o     = cur_q.byte_kind;
      byte_out_o = cur_q.bytes[7:0];
      status_o   = ST_OK;
      last_o     = (cur_q.nbytes == JobCntW'(1)) && !cur_q.fin;
    end else begin
      kind_o     = K_FIN;
      byte_out_o = 8'h00;
      status_o   = cur_q.status;
      last_o     = 1'b1;
    end
  end

  assign out_valid_o = cur_valid_q;
  assign fire        = cur_valid_q & out_ready_i;
  assign load        = !cur_valid_q || (fire && last_o);
  assign job_ready_o = load;

  // job register: load a new job or step through the current one
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
    end else if (load) begin
      cur_valid_q <= job_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cur_q <= job_i;
    end else if (fire) begin
      cur_q.bytes  <= {8'h00, cur_q.bytes[8*JobBytes-1:8]};
      cur_q.nbytes <= cur_q.nbytes - JobCntW'(1);
    end
  end

endmodule

`default_nettype wire

FILE: design/bootloader_memory_command_engine_core.sv
// Host side of a UART bootloader's write-memory and read-memory commands.
// A start beat (tuser 0 write, 1 read) carries address and block length;
// the engine sends the command byte pair, waits for ACK, sends the address
// and its checksum, then the length and data (write) or the length pair
// followed by forwarding received bytes (read). Received link bytes come in
// with tuser 3, write data with tuser 2. Each finish beat carries a status.
// Input beats are taken one per cycle while the two-entry job queue has
// room; every beat yields up to five result beats, which leave at one per
// cycle while the result port is ready, so the single result port sets
// the pace; a beat may also yield no result beat at all. No clearing pass
// after reset.
`default_nettype none

module bootloader_memory_command_engine_core
  import bmce_pkg::*;
#(
  parameter int unsigned MAX_BLOCK_BYTES = MaxBlockBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [55:0] s_axis_tdata_i,  // address[31:0], block_length[40:32],
                                            // byte_in[48:41], zero pad
  input  wire logic [1:0]  s_axis_tuser_i,  // opcode
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,  // byte_out[7:0], status[9:8], zero pad
  output logic [1:0]       m_axis_tuser_o,  // kind
  output logic             m_axis_tlast_o
);

  logic       fr_valid, fr_ready;
  job_t       fr_job;
  logic       bk_valid, bk_ready;
  job_t       bk_job;
  logic [7:0] byte_out;
  logic [1:0] status;

  // front: phase tracking
  bmce_front #(
    .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .opcode_i      (s_axis_tuser_i),
    .address_i     (s_axis_tdata_i[31:0]),
    .block_length_i(s_axis_tdata_i[40:32]),
    .byte_in_i     (s_axis_tdata_i[48:41]),
    .job_valid_o   (fr_valid),
    .job_o         (fr_job),
    .job_ready_i   (fr_ready)
  );

  // queue between the parts
  bmce_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(fr_valid),
    .push_ready_o(fr_ready),
    .push_job_i  (fr_job),
    .pop_valid_o (bk_valid),
    .pop_ready_i (bk_ready),
    .pop_job_o   (bk_job)
  );

  // back: result beats
  bmce_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(bk_valid),
    .job_ready_o(bk_ready),
    .job_i      (bk_job),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .kind_o     (m_axis_tuser_o),
    .byte_out_o (byte_out),
    .status_o   (status),
    .last_o     (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {6'h00, status, byte_out};

endmodule

`default_nettype wire
